>>> rtl/core/ldk_pkg.sv
`timescale 1ns / 1ps
package ldk_pkg;

  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  localparam logic [7:0] KEY_BS        = 8'h08;
  localparam logic [7:0] KEY_LF        = 8'h0A;
  localparam logic [7:0] KEY_CR        = 8'h0D;
  localparam logic [7:0] KEY_SPACE     = 8'h20;
  localparam logic [7:0] KEY_DEL       = 8'h7F;
  localparam logic [7:0] KEY_BACKSLASH = 8'h5C;

  localparam logic [7:0] ACC_ACUTE     = 8'h27;
  localparam logic [7:0] ACC_CEDILLA   = 8'h2C;
  localparam logic [7:0] ACC_TILDE     = 8'h7E;
  localparam logic [7:0] ACC_CIRCUMFLEX = 8'h5E;
  localparam logic [7:0] ACC_GRAVE     = 8'h60;
  localparam logic [7:0] ACC_DIAERESIS = 8'h3A;

  localparam int unsigned SLOT_W = 6;

  // Search request travelling along the accent table cells.
  typedef struct packed {
    logic        active;
    logic        stop;
    logic        hit;
    logic [15:0] pair;
    logic [7:0]  value;
  } ldk_tok_t;

  // Table slot write, broadcast to every cell.
  typedef struct packed {
    logic              en;
    logic [SLOT_W-1:0] index;
    logic [15:0]       source;
    logic [7:0]        result;
  } ldk_wr_t;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       write_enable;
    logic [7:0] write_index;
    logic [7:0] write_data;
    logic       line_done;
    logic [7:0] line_length;
    logic       overflow;
    logic       last;
  } ldk_item_t;

  function automatic logic is_dead_char(input logic [7:0] c);
    return (c == ACC_ACUTE) || (c == ACC_CEDILLA) || (c == ACC_TILDE) ||
           (c == ACC_CIRCUMFLEX) || (c == ACC_GRAVE) || (c == ACC_DIAERESIS);
  endfunction

endpackage

>>> rtl/core/ldk_if.sv
`timescale 1ns / 1ps
interface ldk_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  key_char;
  logic [5:0]  entry_index;
  logic [15:0] entry_source;
  logic [7:0]  entry_result;

  modport source (
    output valid, opcode, key_char, entry_index, entry_source, entry_result,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_char, entry_index, entry_source, entry_result,
    output ready
  );
endinterface

interface ldk_res_if;
  logic       valid;
  logic       ready;
  logic       echo_valid;
  logic [7:0] echo_char;
  logic       write_enable;
  logic [7:0] write_index;
  logic [7:0] write_data;
  logic       line_done;
  logic [7:0] line_length;
  logic       overflow;
  logic       last;

  modport source (
    output valid, echo_valid, echo_char, write_enable, write_index, write_data,
           line_done, line_length, overflow, last,
    input  ready
  );
  modport sink (
    input  valid, echo_valid, echo_char, write_enable, write_index, write_data,
           line_done, line_length, overflow, last,
    output ready
  );
endinterface

>>> rtl/core/ldk_cell.sv
`timescale 1ns / 1ps
module ldk_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ldk_pkg::ldk_wr_t wr_i,
  input  ldk_pkg::ldk_tok_t tok_i,
  output ldk_pkg::ldk_tok_t tok_o
);
  import ldk_pkg::*;

  logic [15:0] key_q;
  logic [7:0]  val_q;
  ldk_tok_t    tok_d, tok_q;

  always_comb begin
    tok_d = tok_i;
    if (tok_i.active && !tok_i.stop) begin
      // An empty slot ends the table; the first matching slot wins.
      if (key_q == 16'd0) begin
        tok_d.stop = 1'b1;
      end else if (key_q == tok_i.pair) begin
        tok_d.stop  = 1'b1;
        tok_d.hit   = 1'b1;
        tok_d.value = val_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
      val_q <= '0;
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
      if (wr_i.en && (32'(wr_i.index) == INDEX)) begin
        key_q <= wr_i.source;
        val_q <= wr_i.result;
      end
    end
  end

  assign tok_o = tok_q;

endmodule

>>> rtl/core/ldk_ctrl.sv
`timescale 1ns / 1ps
module ldk_ctrl #(
  parameter int unsigned LINE_MAX = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ldk_req_if.sink           req_i,
  ldk_res_if.source         res_o,
  output ldk_pkg::ldk_wr_t  wr_o,
  output ldk_pkg::ldk_tok_t launch_o,
  input  ldk_pkg::ldk_tok_t found_i
);
  import ldk_pkg::*;

  localparam int unsigned CUR_W = $clog2(LINE_MAX);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SEARCH = 2'd1;
  localparam logic [1:0] ST_DECIDE = 2'd2;
  localparam logic [1:0] ST_EMIT   = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [7:0]       pending_q, pending_d;
  logic [CUR_W-1:0] cursor_q, cursor_d;
  logic [7:0]       key_q, key_d;
  logic             hit_q, hit_d;
  logic [7:0]       value_q, value_d;
  ldk_item_t        items_q [3];
  ldk_item_t        items_d [3];
  logic [1:0]       num_q, num_d;
  logic [1:0]       sel_q, sel_d;

  logic             req_acc, res_acc;
  logic [CUR_W-1:0] cursor_dec;
  logic [CUR_W+7:0] cur_ext, dec_ext;

  assign req_acc    = req_i.valid && req_i.ready;
  assign res_acc    = res_o.valid && res_o.ready;
  assign cursor_dec = cursor_q - 1'b1;
  assign cur_ext    = {8'd0, cursor_q};
  assign dec_ext    = {8'd0, cursor_dec};

  assign req_i.ready = (state_q == ST_IDLE);

  always_comb begin
    wr_o.en     = req_acc && (req_i.opcode == OP_LOAD);
    wr_o.index  = req_i.entry_index;
    wr_o.source = req_i.entry_source;
    wr_o.result = req_i.entry_result;
  end

  always_comb begin
    launch_o        = '0;
    launch_o.active = req_acc && (req_i.opcode == OP_KEY) && (pending_q != 8'd0) &&
                      (req_i.key_char != KEY_BACKSLASH);
    launch_o.pair   = {pending_q, req_i.key_char};
  end

  always_comb begin
    state_d   = state_q;
    pending_d = pending_q;
    cursor_d  = cursor_q;
    key_d     = key_q;
    hit_d     = hit_q;
    value_d   = value_q;
    items_d   = items_q;
    num_d     = num_q;
    sel_d     = sel_q;

    case (state_q)
      ST_IDLE: begin
        if (req_acc && (req_i.opcode == OP_KEY)) begin
          key_d = req_i.key_char;
          hit_d = 1'b0;
          if (pending_q != 8'd0) begin
            pending_d = 8'd0;
            // A backslash after an accent is dropped without any output.
            if (req_i.key_char != KEY_BACKSLASH) begin
              state_d = ST_SEARCH;
            end
          end else begin
            state_d = ST_DECIDE;
          end
        end
      end

      ST_SEARCH: begin
        if (found_i.active) begin
          hit_d   = found_i.hit;
          value_d = found_i.value;
          state_d = ST_DECIDE;
        end
      end

      ST_DECIDE: begin
        items_d[0] = '0;
        items_d[1] = '0;
        items_d[2] = '0;
        sel_d      = 2'd0;
        if (hit_q) begin
          items_d[0].echo_valid   = 1'b1;
          items_d[0].echo_char    = KEY_BS;
          items_d[0].write_enable = (cursor_q != '0);
          items_d[0].write_index  = (cursor_q != '0) ? dec_ext[7:0] : 8'd0;
          items_d[0].write_data   = (cursor_q != '0) ? value_q : 8'd0;
          items_d[1].echo_valid   = 1'b1;
          items_d[1].echo_char    = value_q;
          items_d[1].last         = 1'b1;
          num_d = 2'd2;
        end else if ((key_q == KEY_LF) || (key_q == KEY_CR)) begin
          items_d[0].echo_valid   = 1'b1;
          items_d[0].echo_char    = KEY_LF;
          items_d[0].write_enable = 1'b1;
          items_d[0].write_index  = cur_ext[7:0];
          items_d[0].line_done    = 1'b1;
          items_d[0].line_length  = cur_ext[7:0];
          items_d[0].last         = 1'b1;
          cursor_d = '0;
          num_d    = 2'd1;
        end else if ((key_q == KEY_BS) || (key_q == KEY_DEL)) begin
          if (cursor_q == '0) begin
            num_d = 2'd0;
          end else begin
            items_d[0].echo_valid = 1'b1;
            items_d[0].echo_char  = KEY_BS;
            items_d[1].echo_valid = 1'b1;
            items_d[1].echo_char  = KEY_SPACE;
            items_d[2].echo_valid = 1'b1;
            items_d[2].echo_char  = KEY_BS;
            items_d[2].last       = 1'b1;
            cursor_d = cursor_dec;
            num_d    = 2'd3;
          end
        end else if (cursor_q >= CUR_W'(LINE_MAX - 1)) begin
          items_d[0].overflow = 1'b1;
          items_d[0].last     = 1'b1;
          num_d = 2'd1;
        end else begin
          if (is_dead_char(key_q)) begin
            pending_d = key_q;
          end
          items_d[0].echo_valid   = 1'b1;
          items_d[0].echo_char    = key_q;
          items_d[0].write_enable = 1'b1;
          items_d[0].write_index  = cur_ext[7:0];
          items_d[0].write_data   = key_q;
          items_d[0].last         = 1'b1;
          cursor_d = cursor_q + 1'b1;
          num_d    = 2'd1;
        end
        state_d = (num_d == 2'd0) ? ST_IDLE : ST_EMIT;
      end

      ST_EMIT: begin
        if (res_acc) begin
          if (sel_q == num_q - 2'd1) begin
            state_d = ST_IDLE;
          end else begin
            sel_d = sel_q + 2'd1;
          end
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      pending_q <= '0;
      cursor_q  <= '0;
      hit_q     <= 1'b0;
      num_q     <= '0;
      sel_q     <= '0;
    end else begin
      state_q   <= state_d;
      pending_q <= pending_d;
      cursor_q  <= cursor_d;
      hit_q     <= hit_d;
      num_q     <= num_d;
      sel_q     <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
    items_q <= items_d;
  end

  always_comb begin
    res_o.valid        = (state_q == ST_EMIT);
    res_o.echo_valid   = items_q[sel_q].echo_valid;
    res_o.echo_char    = items_q[sel_q].echo_char;
    res_o.write_enable = items_q[sel_q].write_enable;
    res_o.write_index  = items_q[sel_q].write_index;
    res_o.write_data   = items_q[sel_q].write_data;
    res_o.line_done    = items_q[sel_q].line_done;
    res_o.line_length  = items_q[sel_q].line_length;
    res_o.overflow     = items_q[sel_q].overflow;
    res_o.last         = items_q[sel_q].last;
  end

endmodule

>>> rtl/core/line_editor_dead_key_compose.sv
`timescale 1ns / 1ps
// Line editor with dead-key accent composition.
// The request channel req_i carries either a key code (opcode 0) or one
// accent table slot to load (opcode 1). The result channel res_o returns
// zero to three items per key: echo bytes, line buffer writes, the end of
// line report and the overflow flag, with last set on the final one.
// One request is handled at a time; req_i.ready is high only when idle.
// A table load gives no result. A key following an accent sends its
// pair down the row of ACCENT_ENTRIES table cells, one cell per cycle,
// before its result is decided. Further result items follow one per
// cycle while res_o.ready is high.
// When the receiver stalls, the current item holds on res_o and no new
// request is taken until every item of the request has been delivered.
// Reset empties the accent table, clears the pending accent and returns
// the cursor to the start of the line; the block is ready straight away.
module line_editor_dead_key_compose #(
  parameter int unsigned LINE_MAX       = 256,
  parameter int unsigned ACCENT_ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ldk_req_if.sink   req_i,
  ldk_res_if.source res_o
);
  import ldk_pkg::*;

  ldk_wr_t  wr;
  ldk_tok_t tok [ACCENT_ENTRIES+1];

  ldk_ctrl #(
    .LINE_MAX (LINE_MAX)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (req_i),
    .res_o    (res_o),
    .wr_o     (wr),
    .launch_o (tok[0]),
    .found_i  (tok[ACCENT_ENTRIES])
  );

  for (genvar i = 0; i < ACCENT_ENTRIES; i++) begin : g_cell
    ldk_cell #(
      .INDEX (i)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .wr_i   (wr),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
  end

endmodule

>>> tb/tb_line_editor_dead_key_compose.sv
`timescale 1ns / 1ps
module tb_line_editor_dead_key_compose;
  import ldk_pkg::*;

  localparam int unsigned LINE_MAX    = 256;
  localparam int unsigned ACC_N       = 64;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned RAND_ITEMS  = 120;
  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic        op;
    logic [7:0]  key;
    logic [5:0]  slot;
    logic [15:0] src;
    logic [7:0]  val;
  } key_req_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  ldk_req_if req ();
  ldk_res_if res ();

  line_editor_dead_key_compose #(
    .LINE_MAX      (LINE_MAX),
    .ACCENT_ENTRIES(ACC_N)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req),
    .res_o (res)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Editor state as the testbench sees it.
  logic [7:0]  acc_held;
  logic [31:0] col;
  logic [15:0] tbl_key [ACC_N];
  logic [7:0]  tbl_val [ACC_N];
  ldk_item_t   editor_out_q [$];

  int unsigned n_requests;
  int unsigned n_items_checked;
  int unsigned n_mismatch;
  int unsigned cycles;
  bit          gaps_on = 1'b1;
  int unsigned hold_reqs;
  int unsigned hold_seen;
  int unsigned hold_left;
  ldk_item_t   rx_item;
  ldk_item_t   rx_want;

  function automatic logic is_dead_key(input logic [7:0] c);
    return c == ACC_ACUTE || c == ACC_CEDILLA || c == ACC_TILDE ||
           c == ACC_CIRCUMFLEX || c == ACC_GRAVE || c == ACC_DIAERESIS;
  endfunction

  function automatic logic [7:0] any_dead_key();
    case ($urandom_range(5))
      0: return ACC_ACUTE;
      1: return ACC_CEDILLA;
      2: return ACC_TILDE;
      3: return ACC_CIRCUMFLEX;
      4: return ACC_GRAVE;
      default: return ACC_DIAERESIS;
    endcase
  endfunction

  task automatic emit(input logic echo, input logic [7:0] ch, input logic wr,
                      input logic [7:0] idx, input logic [7:0] data,
                      input logic done, input logic [7:0] len,
                      input logic ovf, input logic fin);
    ldk_item_t it;
    it.echo_valid   = echo;
    it.echo_char    = echo ? ch : 8'h00;
    it.write_enable = wr;
    it.write_index  = wr ? idx : 8'h00;
    it.write_data   = wr ? data : 8'h00;
    it.line_done    = done;
    it.line_length  = done ? len : 8'h00;
    it.overflow     = ovf;
    it.last         = fin;
    editor_out_q.push_back(it);
  endtask

  task automatic edit_line(input key_req_t r);
    logic [15:0] pair;
    logic [31:0] prev;
    int          i;
    if (r.op == OP_LOAD) begin
      tbl_key[r.slot] = r.src;
      tbl_val[r.slot] = r.val;
      return;
    end
    if (acc_held != 8'h00) begin
      pair     = {acc_held, r.key};
      acc_held = 8'h00;
      if (r.key == KEY_BACKSLASH) return;
      // Slots are searched in order; a zero key marks the end of the table.
      for (i = 0; i < ACC_N; i++) begin
        if (tbl_key[i[5:0]] == 16'h0000) break;
        if (tbl_key[i[5:0]] == pair) begin
          prev = col - 1;
          emit(1'b1, KEY_BS, col != 0, prev[7:0], tbl_val[i[5:0]],
               1'b0, 8'h00, 1'b0, 1'b0);
          emit(1'b1, tbl_val[i[5:0]], 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
          return;
        end
      end
    end
    if (r.key == KEY_LF || r.key == KEY_CR) begin
      emit(1'b1, KEY_LF, 1'b1, col[7:0], 8'h00, 1'b1, col[7:0], 1'b0, 1'b1);
      col = 0;
      return;
    end
    if (r.key == KEY_BS || r.key == KEY_DEL) begin
      if (col == 0) return;
      col = col - 1;
      emit(1'b1, KEY_BS, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
      emit(1'b1, KEY_SPACE, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b0);
      emit(1'b1, KEY_BS, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1);
      return;
    end
    // One cell is always kept free for the terminator.
    if (col >= LINE_MAX - 1) begin
      emit(1'b0, 8'h00, 1'b0, 8'h00, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1);
      return;
    end
    if (is_dead_key(r.key)) acc_held = r.key;
    emit(1'b1, r.key, 1'b1, col[7:0], r.key, 1'b0, 8'h00, 1'b0, 1'b1);
    col = col + 1;
  endtask

  task automatic send_req(input key_req_t r);
    while (gaps_on && $urandom_range(99) < 35) begin
      req.valid <= 1'b0;
      @(posedge clk_i);
    end
    req.valid        <= 1'b1;
    req.opcode       <= r.op;
    req.key_char     <= r.key;
    req.entry_index  <= r.slot;
    req.entry_source <= r.src;
    req.entry_result <= r.val;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    edit_line(r);
    n_requests++;
  endtask

  task automatic press(input logic [7:0] c);
    key_req_t r;
    r.op   = OP_KEY;
    r.key  = c;
    r.slot = 6'($urandom_range(63));
    r.src  = 16'($urandom_range(16'hFFFF));
    r.val  = 8'($urandom_range(255));
    send_req(r);
  endtask

  task automatic load_slot(input logic [5:0] slot, input logic [15:0] src,
                           input logic [7:0] val);
    key_req_t r;
    r.op   = OP_LOAD;
    r.key  = 8'($urandom_range(255));
    r.slot = slot;
    r.src  = src;
    r.val  = val;
    send_req(r);
  endtask

  // The request line is withdrawn first so that nothing is taken twice.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (editor_out_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_plain_keys();
    press(8'h00);
    press(8'hFF);
    press(8'h80);
    press(8'h61);
    press(KEY_DEL);
    press(KEY_BS);
    press(KEY_BS);
    press(KEY_BS);
    press(KEY_BS);
    press(8'h6B);
    press(KEY_CR);
    press(KEY_LF);
    press(KEY_DEL);
  endtask

  task automatic test_accent_table();
    load_slot(6'd0, {ACC_ACUTE, 8'h65}, 8'hE9);
    load_slot(6'd1, {ACC_TILDE, 8'h6E}, 8'hF1);
    load_slot(6'd2, {ACC_CEDILLA, KEY_BS}, 8'hC7);
    load_slot(6'd3, {ACC_ACUTE, 8'h65}, 8'h00);
    load_slot(6'd4, 16'h0000, 8'hFF);
    load_slot(6'd5, {ACC_CIRCUMFLEX, 8'h61}, 8'hE2);
    load_slot(6'd63, 16'hFFFF, 8'hFF);
    press(8'h63);
    press(ACC_ACUTE);
    press(8'h65);
    press(ACC_TILDE);
    press(8'h6E);
    // The circumflex pair lies beyond the end marker and must not be found.
    press(ACC_CIRCUMFLEX);
    press(8'h61);
    press(ACC_GRAVE);
    press(KEY_BACKSLASH);
    press(ACC_CEDILLA);
    press(KEY_BS);
    press(ACC_DIAERESIS);
    press(KEY_CR);
    press(ACC_ACUTE);
    press(ACC_ACUTE);
    press(8'h78);
    load_slot(6'd4, {ACC_CIRCUMFLEX, 8'h6F}, 8'hF4);
    press(ACC_CIRCUMFLEX);
    press(8'h61);
  endtask

  task automatic test_full_line();
    int unsigned n;
    logic [7:0]  c;
    press(KEY_CR);
    load_slot(6'd0, {ACC_ACUTE, 8'h65}, 8'hE9);
    for (n = 0; n < LINE_MAX - 2; n++) begin
      do c = 8'($urandom_range(255));
      while (is_dead_key(c) || c == KEY_BS || c == KEY_DEL ||
             c == KEY_CR || c == KEY_LF);
      press(c);
    end
    // The accent takes the last free cell and still composes in place.
    press(ACC_ACUTE);
    press(8'h65);
    press(8'h71);
    press(ACC_TILDE);
    press(8'h6E);
    press(KEY_DEL);
    press(8'h7A);
    press(KEY_CR);
    wait_drained();
  endtask

  task automatic test_stalled_display();
    int unsigned n;
    logic [7:0]  c;
    wait_drained();
    hold_reqs++;
    for (n = 0; n < 4; n++) begin
      c = 8'h61 + n[7:0];
      press(c);
      press(KEY_BS);
    end
    wait_drained();
    press(8'h62);
    press(KEY_CR);
    wait_drained();
  endtask

  task automatic test_random_typing();
    int unsigned n;
    int unsigned start;
    int unsigned pick;
    logic [5:0]  j;
    logic [7:0]  base;
    logic [15:0] src;
    // A full table without an end marker makes every miss walk all slots.
    for (n = 0; n < ACC_N; n++) begin
      base = 8'($urandom_range(255));
      load_slot(n[5:0], {any_dead_key(), base}, 8'($urandom_range(255)));
    end
    start = n_requests;
    while (n_requests - start < RAND_ITEMS) begin
      gaps_on = (n_requests - start < 40) || (n_requests - start >= 80);
      pick = $urandom_range(99);
      if (pick < 30) begin
        j = 6'($urandom_range(ACC_N - 1));
        press(tbl_key[j][15:8]);
        press(tbl_key[j][7:0]);
      end else if (pick < 50) begin
        press(8'h61 + 8'($urandom_range(25)));
      end else if (pick < 62) begin
        press($urandom_range(1) ? KEY_BS : KEY_DEL);
      end else if (pick < 68) begin
        press($urandom_range(1) ? KEY_CR : KEY_LF);
      end else if (pick < 73) begin
        press(any_dead_key());
        press(KEY_BACKSLASH);
      end else if (pick < 80) begin
        src = ($urandom_range(7) == 0) ? 16'h0000 : 16'($urandom_range(16'hFFFF));
        load_slot(6'($urandom_range(63)), src, 8'($urandom_range(255)));
      end else begin
        press(8'($urandom_range(255)));
      end
    end
    gaps_on = 1'b1;
  endtask

  task automatic cmp_field(input string name, input logic [7:0] want,
                           input logic [7:0] seen);
    if (want !== seen) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
      n_mismatch++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res.valid && res.ready) begin
      rx_item.echo_valid   = res.echo_valid;
      rx_item.echo_char    = res.echo_char;
      rx_item.write_enable = res.write_enable;
      rx_item.write_index  = res.write_index;
      rx_item.write_data   = res.write_data;
      rx_item.line_done    = res.line_done;
      rx_item.line_length  = res.line_length;
      rx_item.overflow     = res.overflow;
      rx_item.last         = res.last;
      if (editor_out_q.size() == 0) begin
        $error("result item with none expected, echo_char 0x%0h", rx_item.echo_char);
        n_mismatch++;
      end else begin
        rx_want = editor_out_q.pop_front();
        cmp_field("echo_valid", 8'(rx_want.echo_valid), 8'(rx_item.echo_valid));
        cmp_field("echo_char", rx_want.echo_char, rx_item.echo_char);
        cmp_field("write_enable", 8'(rx_want.write_enable), 8'(rx_item.write_enable));
        cmp_field("write_index", rx_want.write_index, rx_item.write_index);
        cmp_field("write_data", rx_want.write_data, rx_item.write_data);
        cmp_field("line_done", 8'(rx_want.line_done), 8'(rx_item.line_done));
        cmp_field("line_length", rx_want.line_length, rx_item.line_length);
        cmp_field("overflow", 8'(rx_want.overflow), 8'(rx_item.overflow));
        cmp_field("last", 8'(rx_want.last), 8'(rx_item.last));
        n_items_checked++;
      end
    end
  end

  // Display side: random stalls while gaps_on is set, plus one long hold when a test asks for it.
  initial begin
    res.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_seen != hold_reqs) begin
        hold_seen = hold_reqs;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        res.ready <= 1'b0;
      end else if (gaps_on) begin
        res.ready <= ($urandom_range(99) >= 35);
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: timeout after %0d cycles", cycles);
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst_ni             <= 1'b0;
    req.valid          <= 1'b0;
    req.opcode         <= OP_KEY;
    req.key_char       <= 8'h00;
    req.entry_index    <= 6'd0;
    req.entry_source   <= 16'h0000;
    req.entry_result   <= 8'h00;
    acc_held = 8'h00;
    col      = 0;
    for (int i = 0; i < ACC_N; i++) begin
      tbl_key[i[5:0]] = 16'h0000;
      tbl_val[i[5:0]] = 8'h00;
    end
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_keys();
    test_accent_table();
    test_full_line();
    test_stalled_display();
    test_random_typing();
    wait_drained();
    repeat (4 * ACC_N) @(posedge clk_i);
    $display("tb: %0d requests sent, %0d result items checked, %0d mismatches",
             n_requests, n_items_checked, n_mismatch);
    $display("tb: covered erase, line end, composition, table end, backslash, full line, stalls");
    if (n_mismatch == 0 && editor_out_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
